>>> hw/rtl/rss_pkg.sv
// Shared definitions for the running sample statistics core.
// Holds default field widths and the status bundle of the iterative units.
// No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

  // Default field widths
  localparam int RSS_COUNT_BITS  = 24;
  localparam int RSS_SAMPLE_BITS = 16;

  // Status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;  // iterating
    logic done;  // one-cycle pulse: result valid from this cycle on
  } rss_unit_stat_t;

endpackage

>>> hw/rtl/rss_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, dividend MSB first.
// Depends on rss_pkg for the unit status bundle.
`timescale 1ns / 1ps

module rss_divider import rss_pkg::*; #(
  parameter int DIVIDEND_W = 56,
  parameter int DIVISOR_W  = 24,
  parameter int QUOTIENT_W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [QUOTIENT_W-1:0] quotient,
  output rss_unit_stat_t        stat
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [QUOTIENT_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    trial    = {rem_r, dvd_r[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = dvd_r << 1;
      rem_nxt  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[QUOTIENT_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/rss_isqrt.sv
// Digit-serial floor square root: two radicand bits and one root bit per cycle.
// Depends on rss_pkg for the unit status bundle.
`timescale 1ns / 1ps

module rss_isqrt import rss_pkg::*; #(
  parameter int ROOT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output rss_unit_stat_t        stat
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STEP_W = $clog2(ROOT_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] test;
  logic [ROOT_W+2:0] diff;
  logic              fits;

  // Bring down two bits, try 4*root+1 against the partial remainder
  always_comb begin
    trial    = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    test     = {1'b0, root_r, 2'b01};
    diff     = trial - test;
    fits     = (trial >= test);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = fits ? diff[ROOT_W:0] : trial[ROOT_W:0];
      root_nxt = {root_r[ROOT_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/running_sample_statistics_core.sv
// Running min / max / mean / standard deviation of a signed sample stream.
// A sample runs through the squarer, both dividers, a second squaring and the root unit;
// a sample dropped on a full count skips the first squaring and the update, a clear goes to emit.
// One item at a time, the next taken the cycle after a result loads.
// A result may wait at the output.
// Synchronous active-low reset empties the statistics. Uses rss_pkg, rss_divider, rss_isqrt.
`timescale 1ns / 1ps

module running_sample_statistics_core import rss_pkg::*; #(
  parameter int COUNT_BITS  = RSS_COUNT_BITS,
  parameter int SAMPLE_BITS = RSS_SAMPLE_BITS,
  localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = COUNT_BITS + 4 * SAMPLE_BITS - 1,
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_value
  input  logic                   in_tuser,   // action (1 = clear)
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // total_samples, lowest, highest, average, spread
  output logic [1:0]             out_tuser   // is_empty, is_full
);

  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SAMPLE_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] C_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIVIDE,
    ST_MEAN_SQ,
    ST_VAR,
    ST_ROOT,
    ST_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic signed [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]               sqsum_r, sqsum_nxt;
  logic [COUNT_BITS-1:0]         tally_r, tally_nxt;
  logic                          full_r, full_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SAMPLE_BITS-1:0]        mul_m_r, mul_m_nxt;
  logic [SAMPLE_BITS-1:0]        mul_b_r, mul_b_nxt;
  logic [PROD_W-1:0]             mul_acc_r, mul_acc_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]        out_tdata_r, out_tdata_nxt;
  logic [1:0]                    out_tuser_r, out_tuser_nxt;

  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [SAMPLE_BITS-1:0]        in_mag;
  logic [SAMPLE_BITS-1:0]        add_term;
  logic [SAMPLE_BITS:0]          partial;
  logic [SUM_W-1:0]              sum_mag;
  logic                          div_start;
  logic [SAMPLE_BITS-1:0]        mean_q;
  logic [PROD_W-1:0]             msq_q;
  rss_unit_stat_t                mean_stat;
  rss_unit_stat_t                msq_stat;
  logic                          root_start;
  logic [PROD_W-1:0]             variance;
  logic [SAMPLE_BITS-1:0]        root_q;
  rss_unit_stat_t                root_stat;
  logic                          is_empty;
  logic [SAMPLE_BITS-1:0]        avg_out;
  logic [SAMPLE_BITS-2:0]        spread_out;

  // Sample and running-sum magnitudes
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_mag    = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  assign sum_mag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // Shift-add squarer: one multiplier bit per cycle
  assign add_term = mul_b_r[0] ? mul_m_r : '0;
  assign partial  = {1'b0, mul_acc_r[PROD_W-1:SAMPLE_BITS]} + {1'b0, add_term};

  // Mean and mean of squares, both run over the wider dividend
  assign div_start = (state_r == ST_DIV_GO);

  rss_divider #(
    .DIVIDEND_W (SQ_W),
    .DIVISOR_W  (COUNT_BITS),
    .QUOTIENT_W (SAMPLE_BITS)
  ) u_div_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (SQ_W'(sum_mag)),
    .divisor  (tally_r),
    .quotient (mean_q),
    .stat     (mean_stat)
  );

  rss_divider #(
    .DIVIDEND_W (SQ_W),
    .DIVISOR_W  (COUNT_BITS),
    .QUOTIENT_W (PROD_W)
  ) u_div_msq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sqsum_r),
    .divisor  (tally_r),
    .quotient (msq_q),
    .stat     (msq_stat)
  );

  // Clamped variance, then root
  assign root_start = (state_r == ST_VAR);
  assign variance   = (msq_q > mul_acc_r) ? (msq_q - mul_acc_r) : '0;

  rss_isqrt #(
    .ROOT_W (SAMPLE_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (variance),
    .root     (root_q),
    .stat     (root_stat)
  );

  // Result fields
  assign is_empty   = (tally_r == '0);
  assign avg_out    = is_empty ? '0 : (sum_r[SUM_W-1] ? (~mean_q + 1'b1) : mean_q);
  assign spread_out = is_empty ? '0 :
                      (root_q[SAMPLE_BITS-1] ? {(SAMPLE_BITS-1){1'b1}}
                                             : root_q[SAMPLE_BITS-2:0]);

  assign in_tready = (state_r == ST_IDLE);

  // Sequence one item: square, update, divide, square, root, emit; clears and drops skip steps
  always_comb begin
    state_nxt      = state_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    sum_nxt        = sum_r;
    sqsum_nxt      = sqsum_r;
    tally_nxt      = tally_r;
    full_nxt       = full_r;
    sample_nxt     = sample_r;
    mul_m_nxt      = mul_m_r;
    mul_b_nxt      = mul_b_r;
    mul_acc_nxt    = mul_acc_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    // Drop the result once transferred
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            low_nxt   = S_MAX;
            high_nxt  = S_MIN;
            sum_nxt   = '0;
            sqsum_nxt = '0;
            tally_nxt = '0;
            full_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else if (tally_r == C_MAX) begin
            full_nxt  = 1'b1;
            state_nxt = ST_DIV_GO;
          end else begin
            full_nxt    = 1'b0;
            sample_nxt  = in_sample;
            mul_m_nxt   = in_mag;
            mul_b_nxt   = in_mag;
            mul_acc_nxt = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_SQUARE;
          end
        end
      end
      ST_SQUARE, ST_MEAN_SQ: begin
        mul_acc_nxt = {partial, mul_acc_r[SAMPLE_BITS-1:1]};
        mul_b_nxt   = mul_b_r >> 1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          state_nxt = (state_r == ST_SQUARE) ? ST_UPDATE : ST_VAR;
        end
      end
      ST_UPDATE: begin
        if (sample_r < low_r) begin
          low_nxt = sample_r;
        end
        if (sample_r > high_r) begin
          high_nxt = sample_r;
        end
        sum_nxt   = sum_r + SUM_W'(sample_r);
        sqsum_nxt = sqsum_r + SQ_W'(mul_acc_r);
        tally_nxt = tally_r + 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (mean_stat.done && msq_stat.done) begin
          mul_m_nxt   = mean_q;
          mul_b_nxt   = mean_q;
          mul_acc_nxt = '0;
          cnt_nxt     = '0;
          state_nxt   = ST_MEAN_SQ;
        end
      end
      ST_VAR: begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({spread_out, avg_out, high_r, low_r, tally_r});
          out_tuser_nxt  = {full_r, is_empty};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, statistics and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      low_r        <= S_MAX;
      high_r       <= S_MIN;
      sum_r        <= '0;
      sqsum_r      <= '0;
      tally_r      <= '0;
      full_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      sum_r        <= sum_nxt;
      sqsum_r      <= sqsum_nxt;
      tally_r      <= tally_nxt;
      full_r       <= full_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    sample_r    <= sample_nxt;
    mul_m_r     <= mul_m_nxt;
    mul_b_r     <= mul_b_nxt;
    mul_acc_r   <= mul_acc_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Both dividers start together and must finish together
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mean_stat.done == msq_stat.done)
    else $error("dividers out of step");

  // No unit may still be working once a new item can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mean_stat.busy && !msq_stat.busy && !root_stat.busy))
    else $error("arithmetic unit busy while idle");

  // The count only steps up by one or returns to zero on a clear
  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tally_r != $past(tally_r)) |-> (tally_r == $past(tally_r) + 1'b1 || tally_r == '0))
    else $error("sample count jumped");

  // A new result is loaded only from the emit step
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised outside emit");

endmodule
